// ===== sv/lkvc_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
// No dependencies; used by lru_key_value_cache_top.
package lkvc_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CapW   = 5;

  localparam logic [CapW-1:0]  CapacityReset = 5'd16;
  localparam logic [DataW-1:0] MissData      = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    FUNC_LOOKUP = 1'b0,
    FUNC_STORE  = 1'b1
  } func_e;

endpackage

// ===== sv/lru_key_value_cache_top.sv =====
// Fully associative key-value cache with least-recently-used replacement.
// Depends on lkvc_pkg (types and constants).
//
// Usage:
//   A request (func_i, key_i, data_in_i) is taken at a clock edge where
//   start_i is high and busy_o is low. busy_o stays low: a request may be
//   issued in every cycle. func_i selects a lookup or a store.
//   The request is registered on acceptance; in the following cycle all keys are
//   compared in parallel, recency ranks are updated and the result is
//   registered. A lookup therefore shows its result from the result register:
//   found_o and data_out_o are valid for exactly one cycle while result_valid_o
//   is high. A miss returns all ones with found_o low. A store produces no
//   result. Throughput is one request per cycle, set by the single registered
//   pass over the parallel key compare.
//   There is no stall on the result side; results must be taken when shown.
//   capacity is written through cfg_we_i / cfg_wdata_i; the user must do so
//   only while idle, which the block does not enforce. Zero acts as one, values
//   above ENTRIES act as ENTRIES. Reset empties the cache (all entries invalid,
//   count zero) and sets the capacity to 16. Key and value storage is not reset.
module lru_key_value_cache_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                func_i,
  input  logic signed [lkvc_pkg::KeyW-1:0]    key_i,
  input  logic signed [lkvc_pkg::DataW-1:0]   data_in_i,
  output logic                                result_valid_o,
  output logic                                found_o,
  output logic signed [lkvc_pkg::DataW-1:0]   data_out_o,
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CapW-1:0]           cfg_wdata_i
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned WW = (CW > lkvc_pkg::CapW) ? CW : lkvc_pkg::CapW;

  // request register
  logic                         req_valid_q;
  lkvc_pkg::func_e              req_func_q;
  logic [lkvc_pkg::KeyW-1:0]    req_key_q;
  logic [lkvc_pkg::DataW-1:0]   req_data_q;

  // cache state
  logic [lkvc_pkg::KeyW-1:0]    key_q   [ENTRIES];
  logic [lkvc_pkg::DataW-1:0]   value_q [ENTRIES];
  logic [ENTRIES-1:0]           valid_q, valid_d;
  logic [AW-1:0]                age_q   [ENTRIES];
  logic [AW-1:0]                age_d   [ENTRIES];
  logic [CW-1:0]                count_q, count_d;
  logic [lkvc_pkg::CapW-1:0]    cap_q;

  // result register
  logic                         res_valid_q, res_valid_d;
  logic                         res_found_q, res_found_d;
  logic [lkvc_pkg::DataW-1:0]   res_data_q,  res_data_d;

  // lookup / replacement
  logic [ENTRIES-1:0]           match;
  logic                         hit;
  logic [AW-1:0]                hit_idx;
  logic [AW-1:0]                hit_age;
  logic [AW-1:0]                last_age;
  logic [AW-1:0]                victim_idx;
  logic [AW-1:0]                free_idx;
  logic [WW-1:0]                eff_cap;
  logic                         evict;
  logic                         wr_en;
  logic                         wr_key_en;
  logic [AW-1:0]                wr_idx;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_func_q <= lkvc_pkg::func_e'(func_i);
      req_key_q  <= key_i;
      req_data_q <= data_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapacityReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // capacity clamped to 1..ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = WW'(1);
    end else if (WW'(cap_q) > WW'(ENTRIES)) begin
      eff_cap = WW'(ENTRIES);
    end else begin
      eff_cap = WW'(cap_q);
    end
  end

  assign last_age = AW'(count_q - CW'(1));

  // keys are unique among valid entries, so matches and the oldest rank
  // are one-hot and an OR of indices encodes them
  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_key_q);
      if (match[i]) begin
        hit_idx = hit_idx | AW'(i);
      end
      if (valid_q[i] && (age_q[i] == last_age)) begin
        victim_idx = victim_idx | AW'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = AW'(i);
      end
    end
  end

  assign hit     = |match;
  assign hit_age = age_q[hit_idx];
  assign evict   = WW'(count_q) >= eff_cap;

  always_comb begin
    valid_d     = valid_q;
    age_d       = age_q;
    count_d     = count_q;
    wr_en       = 1'b0;
    wr_key_en   = 1'b0;
    wr_idx      = hit_idx;
    res_valid_d = 1'b0;
    res_found_d = 1'b0;
    res_data_d  = lkvc_pkg::MissData;

    if (req_valid_q) begin
      if (req_func_q == lkvc_pkg::FUNC_LOOKUP) begin
        res_valid_d = 1'b1;
        res_found_d = hit;
        if (hit) begin
          res_data_d = value_q[hit_idx];
        end
      end

      if (hit) begin
        // move to front: younger entries age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && (age_q[i] < hit_age)) begin
            age_d[i] = age_q[i] + AW'(1);
          end
        end
        age_d[hit_idx] = '0;
        wr_en = (req_func_q == lkvc_pkg::FUNC_STORE);
      end else if (req_func_q == lkvc_pkg::FUNC_STORE) begin
        wr_idx    = evict ? victim_idx : free_idx;
        wr_en     = 1'b1;
        wr_key_en = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_q[i] && !(evict && (AW'(i) == victim_idx))) begin
            age_d[i] = age_q[i] + AW'(1);
          end
        end
        valid_d[wr_idx] = 1'b1;
        age_d[wr_idx]   = '0;
        if (!evict) begin
          count_d = count_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q     <= valid_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      age_q       <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_found_q <= res_found_d;
    res_data_q  <= res_data_d;
    if (wr_en) begin
      value_q[wr_idx] <= req_data_q;
    end
    if (wr_key_en) begin
      key_q[wr_idx] <= req_key_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign found_o        = res_found_q;
  assign data_out_o     = res_data_q;

  // a result only follows a registered lookup request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(req_valid_q && (req_func_q == lkvc_pkg::FUNC_LOOKUP)))
    else $error("result without a lookup request");

  // the fill count tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("entry count out of step with valid bits");

  // a miss always returns all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (data_out_o == lkvc_pkg::MissData))
    else $error("miss with data other than all ones");

  // a store to a new key never leaves the cache empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && (req_func_q == lkvc_pkg::FUNC_STORE) && !hit) |=>
      (count_q != '0))
    else $error("cache empty after a store");

endmodule
